@@ rtl/ebr_pkg.sv @@
// Shared types, sizes and codes of the Exp-Golomb bit reader.
// No dependencies; ebr_zero_scan and the top level import this package, ebr_byte_ram does not.
`default_nettype none

package ebr_pkg;

    // Buffer geometry
    localparam int BUFFER_BYTES = 256;
    localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int POS_W = CNT_W + 3;                    // bit offset into the buffer
    localparam int CALC_W = ((POS_W > 12) ? POS_W : 12) + 1;
    localparam int LEFT_MAX = 4095;
    localparam int MAX_READ = 32;
    localparam int ZCNT_W = 6;                           // prefix length and bits to read

    // Command codes
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_APPEND  = 3'd1;
    localparam logic [2:0] CMD_READ    = 3'd2;
    localparam logic [2:0] CMD_SKIP    = 3'd3;
    localparam logic [2:0] CMD_READ_UE = 3'd4;
    localparam logic [2:0] CMD_READ_SE = 3'd5;
    localparam logic [2:0] CMD_SKIP_EG = 3'd6;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_DATA   = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_TOO_MANY  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  data_byte;
        logic [11:0] bit_count;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        value;
        logic signed [31:0] signed_value;
        logic [2:0]         status;
        logic [11:0]        bits_left;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREFIX,
        S_SUFFIX,
        S_BITS,
        S_CODE,
        S_SIGN
    } t_state;

    // Zero search over the unread part of one byte
    typedef struct packed {
        logic       found;   // a one bit follows the zeros
        logic [3:0] zrun;    // zeros before it, or all unread bits if none
    } t_scan;

endpackage

`default_nettype wire

@@ rtl/ebr_byte_ram.sv @@
// Byte store of the bit reader: one write port, one read port, registered read.
// Write-to-read forwarding when both ports hit the same entry. No dependencies.
`default_nettype none

module ebr_byte_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/ebr_zero_scan.sv @@
// Leading-zero search over the unread bits of the current buffer byte.
// Depends on ebr_pkg (t_scan).
`default_nettype none

module ebr_zero_scan
    import ebr_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic [2:0] i_offset,
    output t_scan      o_scan
);

    // Walk from the last bit back so the first one at or after the offset wins.
    always_comb begin
        o_scan.found = 1'b0;
        o_scan.zrun  = 4'd8 - {1'b0, i_offset};
        for (int i = 7; i >= 0; i--) begin
            if ((3'(i) >= i_offset) && i_byte[7 - i]) begin
                o_scan.found = 1'b1;
                o_scan.zrun  = 4'(i) - {1'b0, i_offset};
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/exp_golomb_bit_reader.sv @@
// Top level of the Exp-Golomb bit reader: command decode, sequencer and result register.
// Depends on ebr_pkg, ebr_byte_ram and ebr_zero_scan.
`default_nettype none

// Usage
//   Command channel: a command transfer happens at a rising edge with start high
//   and busy low. i_item carries cmd, data_byte and bit_count.
//   Result channel: o_done is high for exactly one cycle and o_result then holds
//   value, signed_value, status and bits_left. The receiver cannot hold it off.
// Command timing
//   Clear, append, skip bits, unused codes and rejected commands finish in the
//   accept cycle: the result shows the next cycle and busy never rises.
//   Read bits: the bits state takes up to the rest of the current buffer byte per step.
//   Exp-Golomb: prefix scan byte by byte, suffix check, suffix bits byte by byte,
//   then the code step, and the sign step for se; skip Exp-Golomb ends after the suffix check.
//   A prefix that runs out of data ends in a further prefix step that sees no bits left.
//   The pace is set by the byte store's single read port: one byte per cycle.
//   A new command may be given in the cycle its predecessor's result shows.
// Reset
//   Synchronous, active low: buffer empty, position zero, no result pending.
//   Store contents are not cleared; reads never go past the filled part.

module exp_golomb_bit_reader
    import ebr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result
);

    // Bits still unread for a given fill and position.
    function automatic logic [CALC_W-1:0] f_rem(input logic [CNT_W-1:0] cnt,
                                                input logic [POS_W-1:0] pos);
        logic [CALC_W-1:0] end_bits;
        logic [CALC_W-1:0] pos_ext;
        end_bits = CALC_W'({cnt, 3'b000});
        pos_ext  = CALC_W'(pos);
        return (end_bits > pos_ext) ? (end_bits - pos_ext) : '0;
    endfunction

    // State
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [POS_W-1:0]    r_pos, n_pos;     // byte position and bit position in one offset
    logic [2:0]          r_cmd, n_cmd;
    logic [ZCNT_W-1:0]   r_need, n_need;
    logic [ZCNT_W-1:0]   r_zeros, n_zeros;
    logic [31:0]         r_acc, n_acc;
    logic                r_done, n_done;
    t_out_item           r_res, n_res;

    // Store and scan
    logic                ram_we;
    logic [7:0]          r_rdata;          // always the byte at r_pos
    t_scan               scan;

    // Shared decode
    logic                accept;
    logic [CALC_W-1:0]   rem;
    logic [CALC_W-1:0]   cnt_ext;
    logic                cnt_over;         // read wider than a word
    logic                cnt_short;        // not enough data for read or skip
    logic                rd_start;
    logic                eg_cmd;
    logic [ZCNT_W-1:0]   pfx_total;
    logic                pfx_bad;
    logic [ZCNT_W-1:0]   pfx_take;
    logic                sfx_short;
    logic [3:0]          avail;
    logic [3:0]          take;
    logic [7:0]          window;
    logic [7:0]          chunk;
    logic                bits_last;
    logic [31:0]         code;
    logic [31:0]         half;
    logic [CALC_W-1:0]   n_rem;

    assign accept    = start && !busy;
    assign rem       = f_rem(r_count, r_pos);
    assign cnt_ext   = CALC_W'(i_item.bit_count);
    assign cnt_over  = i_item.bit_count > 12'(MAX_READ);
    assign cnt_short = cnt_ext > rem;
    assign rd_start  = (i_item.cmd == CMD_READ) && !cnt_over && !cnt_short
                       && (i_item.bit_count != '0);
    assign eg_cmd    = (i_item.cmd == CMD_READ_UE) || (i_item.cmd == CMD_READ_SE)
                       || (i_item.cmd == CMD_SKIP_EG);

    // Prefix: zeros in this byte, capped so that the 32nd zero ends the scan
    assign pfx_total = r_zeros + ZCNT_W'(scan.zrun);
    assign pfx_bad   = pfx_total >= ZCNT_W'(MAX_READ);
    always_comb begin
        priority if (pfx_bad) begin
            pfx_take = ZCNT_W'(MAX_READ) - r_zeros;
        end else if (scan.found) begin
            pfx_take = ZCNT_W'(scan.zrun) + 1'b1;   // zeros plus the marker one
        end else begin
            pfx_take = ZCNT_W'(scan.zrun);
        end
    end

    assign sfx_short = CALC_W'(r_zeros) > rem;

    // Bit extraction: up to the rest of the current byte per cycle
    assign avail     = 4'd8 - {1'b0, r_pos[2:0]};
    assign take      = (r_need < ZCNT_W'(avail)) ? r_need[3:0] : avail;
    assign window    = r_rdata << r_pos[2:0];
    assign chunk     = window >> (4'd8 - take);
    assign bits_last = r_need == ZCNT_W'(take);

    // Code number and signed mapping
    assign code = ~(32'hFFFF_FFFF << r_zeros) + r_acc;
    assign half = {1'b0, r_acc[31:1]};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (rd_start) begin
                        n_state = S_BITS;
                    end else if (eg_cmd) begin
                        n_state = S_PREFIX;
                    end
                end
            end
            S_PREFIX: begin
                if ((rem == '0) || pfx_bad) begin
                    n_state = S_IDLE;
                end else if (scan.found) begin
                    n_state = S_SUFFIX;
                end
            end
            S_SUFFIX: begin
                if (sfx_short || (r_cmd == CMD_SKIP_EG)) begin
                    n_state = S_IDLE;
                end else if (r_zeros == '0) begin
                    n_state = S_CODE;
                end else begin
                    n_state = S_BITS;
                end
            end
            S_BITS: begin
                if (bits_last) begin
                    n_state = (r_cmd == CMD_READ) ? S_IDLE : S_CODE;
                end
            end
            S_CODE: begin
                n_state = (r_cmd == CMD_READ_SE) ? S_SIGN : S_IDLE;
            end
            S_SIGN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_cmd   = r_cmd;
        n_need  = r_need;
        n_zeros = r_zeros;
        n_acc   = r_acc;
        n_done  = 1'b0;
        ram_we  = 1'b0;
        n_res              = r_res;
        n_res.value        = '0;
        n_res.signed_value = '0;
        n_res.status       = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_item.cmd;
                    n_done = 1'b1;
                    priority case (i_item.cmd)
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_pos   = '0;
                        end
                        CMD_APPEND: begin
                            if (r_count >= CNT_W'(BUFFER_BYTES)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_READ: begin
                            priority if (cnt_over) begin
                                n_res.status = ST_TOO_MANY;
                            end else if (cnt_short) begin
                                n_res.status = ST_NO_DATA;
                            end else if (rd_start) begin
                                n_done = 1'b0;
                                n_need = ZCNT_W'(i_item.bit_count);
                                n_acc  = '0;
                            end else begin
                                n_res.status = ST_OK;     // zero-width read
                            end
                        end
                        CMD_SKIP: begin
                            if (cnt_short) begin
                                n_res.status = ST_NO_DATA;
                            end else begin
                                n_pos = r_pos + POS_W'(i_item.bit_count);
                            end
                        end
                        CMD_READ_UE, CMD_READ_SE, CMD_SKIP_EG: begin
                            n_done  = 1'b0;
                            n_zeros = '0;
                        end
                        default: begin
                            n_res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_PREFIX: begin
                if (rem == '0) begin
                    n_done       = 1'b1;
                    n_res.status = ST_NO_DATA;
                end else begin
                    n_pos   = r_pos + POS_W'(pfx_take);
                    n_zeros = pfx_total;
                    if (pfx_bad) begin
                        n_done       = 1'b1;
                        n_res.status = ST_MALFORMED;
                    end
                end
            end
            S_SUFFIX: begin
                n_acc  = '0;
                n_need = r_zeros;
                if (sfx_short) begin
                    n_done       = 1'b1;
                    n_res.status = ST_NO_DATA;
                end else if (r_cmd == CMD_SKIP_EG) begin
                    n_done = 1'b1;
                    n_pos  = r_pos + POS_W'(r_zeros);
                end
            end
            S_BITS: begin
                n_acc  = (r_acc << take) | 32'(chunk);
                n_pos  = r_pos + POS_W'(take);
                n_need = r_need - ZCNT_W'(take);
                if (bits_last && (r_cmd == CMD_READ)) begin
                    n_done      = 1'b1;
                    n_res.value = n_acc;
                end
            end
            S_CODE: begin
                n_acc = code;
                if (r_cmd != CMD_READ_SE) begin
                    n_done      = 1'b1;
                    n_res.value = code;
                end
            end
            S_SIGN: begin
                n_done             = 1'b1;
                n_res.signed_value = $signed(r_acc[0] ? (half + 32'd1) : (32'd0 - half));
            end
            default: begin
                n_done = 1'b0;
            end
        endcase

        n_rem = f_rem(n_count, n_pos);
        n_res.bits_left = (n_rem > CALC_W'(LEFT_MAX)) ? 12'(LEFT_MAX) : n_rem[11:0];
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_need  <= n_need;
        r_zeros <= n_zeros;
        r_acc   <= n_acc;
        if (n_done) begin
            r_res <= n_res;
        end
    end

    // Byte store: read address follows the next position so r_rdata tracks r_pos
    ebr_byte_ram #(
        .DEPTH (BUFFER_BYTES),
        .AW    (ADDR_W),
        .DW    (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_item.data_byte),
        .i_raddr (n_pos[ADDR_W+2:3]),
        .o_rdata (r_rdata)
    );

    ebr_zero_scan u_scan (
        .i_byte   (r_rdata),
        .i_offset (r_pos[2:0]),
        .o_scan   (scan)
    );

    assign busy     = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_result = r_res;

    // Checks
    a_done_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("sequencer returned to idle without a result");

    a_one_cycle_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((i_item.cmd == CMD_CLEAR) || (i_item.cmd == CMD_APPEND)
                    || (i_item.cmd == CMD_SKIP)))
        |=> (o_done && !busy))
        else $error("single-cycle command did not finish at once");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK))
        |-> ((o_result.value == '0) && (o_result.signed_value == '0)))
        else $error("error result carries a nonzero value");

    a_bits_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BITS) |-> ((r_need != '0) && (r_need <= ZCNT_W'(MAX_READ))))
        else $error("bit extraction running with a bad count");

    a_too_many_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_TOO_MANY)) |-> (r_pos == $past(r_pos)))
        else $error("rejected read moved the position");

endmodule

`default_nettype wire
